// File: hdl/scc_min_cost_sum_unit_defines.svh
// Assertion macros used by the block's top level.
// No dependencies.
`ifndef SCC_MIN_COST_SUM_UNIT_DEFINES_SVH
`define SCC_MIN_COST_SUM_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SCC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("%m: check failed");
// Implication checked in the cycle after the antecedent.
`define SCC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("%m: check failed");
`endif

// File: hdl/scc_pkg.sv
// Shared constants and types for the SCC minimum cost block.
// No dependencies.
package scc_pkg;
  localparam int unsigned IdxBits  = 6;
  localparam int unsigned InCost   = 16;
  localparam int unsigned RowBits  = 64;
  localparam int unsigned TotBits  = 22;

  // Search control handed from sequencer to the add/compare unit.
  typedef struct packed {
    logic init;  // clear the total for a new graph
    logic clr;   // start a new component
    logic cand;  // offer a cost to the running minimum
    logic close; // add the minimum to the total
  } acc_ctl_t;
endpackage

// File: hdl/scc_acc.sv
// Shared compare/add unit: running minimum and component total.
// Depends on scc_pkg.
module scc_acc #(
  parameter int unsigned COST_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scc_pkg::acc_ctl_t            ctl_i,
  input  logic [COST_BITS-1:0]         cost_i,
  output logic [scc_pkg::TotBits-1:0]  total_o
);
  import scc_pkg::*;

  logic [COST_BITS-1:0] best_q, best_d;
  logic [TotBits-1:0]   tot_q, tot_d;
  logic [TotBits-1:0]   best_ext;

  // Minimum extended or truncated to the total width.
  if (COST_BITS >= TotBits) begin : g_trunc
    assign best_ext = best_q[TotBits-1:0];
  end else begin : g_ext
    assign best_ext = {{(TotBits-COST_BITS){1'b0}}, best_q};
  end

  // One compare or one add per cycle.
  always_comb begin
    best_d = best_q;
    tot_d  = tot_q;
    if (ctl_i.init) begin
      tot_d = '0;
    end else if (ctl_i.clr) begin
      best_d = '1;
    end else if (ctl_i.cand) begin
      if (cost_i < best_q) best_d = cost_i;
    end else if (ctl_i.close) begin
      tot_d = tot_q + best_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q  <= '0;
      best_q <= '0;
    end else begin
      tot_q  <= tot_d;
      best_q <= best_d;
    end
  end

  assign total_o = tot_q;
endmodule

// File: hdl/scc_min_cost_sum_unit.sv
// Top level of the SCC minimum cost block: graph store and search sequencer.
// Depends on scc_pkg, scc_acc and scc_min_cost_sum_unit_defines.svh.
//
// Usage: one input word per node carries node_index_i, node_cost_i,
// adjacency_row_i and last_node_i, accepted when in_valid_i is high and
// in_stall_o is low. A non-last word is stored without a stall, so node words
// load back to back. A last word sets n = index + 1 and starts Kosaraju's two
// passes; in_stall_o stays high until the search ends and the single result
// word, total_min_cost_o, is placed in the output register (out_valid_o high,
// taken when out_stall_i is low).
// Timing: pass one tests one candidate node per cycle, apart from a row read
// after each stack change; pass two reads each candidate's row before testing it.
// While the receiver stalls the output register holds its word and the next
// graph may load; that graph's search waits at its end until the word is taken.
// Reset clears visited marks, stack pointers, the sequencer and valid flags;
// stored graph data keep their contents.
module scc_min_cost_sum_unit #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scc_pkg::IdxBits-1:0] node_index_i,
  input  logic [scc_pkg::InCost-1:0]  node_cost_i,
  input  logic [scc_pkg::RowBits-1:0] adjacency_row_i,
  input  logic                        last_node_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scc_pkg::TotBits-1:0] total_min_cost_o
);
  import scc_pkg::*;
  `include "scc_min_cost_sum_unit_defines.svh"

  localparam int unsigned NB = $clog2(MAX_NODES);
  localparam int unsigned CB = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_P1_ROOT, S_P1_SCAN, S_P1_POP, S_P2_INIT, S_P2_ROOT,
    S_P2_START, S_P2_SCAN, S_P2_CLOSE
  } state_e;

  state_e state_q;
  logic [RowBits-1:0]   adj_mem  [MAX_NODES];
  logic [NB-1:0]        fin_mem  [MAX_NODES];
  logic [NB-1:0]        stk_mem  [MAX_NODES];
  logic [NB:0]          scn_mem  [MAX_NODES];
  logic [COST_BITS-1:0] cst_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] vis_q;
  logic [CB-1:0]        n_q, sp_q, fc_q, k_q;
  logic [NB:0]          i_q;      // pass-one root counter
  logic [NB-1:0]        top_q;    // node on top of stack
  logic [NB:0]          j_q;      // scan position
  logic [RowBits-1:0]   row_q;    // adjacency row read for top (pass one) or j (pass two)
  logic                 out_v_q;
  logic [TotBits-1:0]   out_q;    // result word held for the receiver
  logic                 out_done;
  acc_ctl_t             ctl;
  logic [TotBits-1:0]   total;
  logic [CB-1:0]        n_new;
  logic [COST_BITS-1:0] cost_in;
  logic                 edge_hit;
  logic [NB-1:0]        jn;
  logic                 in_acc;
  logic                 scan_wait_q; // wait for a row read after a stack change or pass-two scan step
  logic                 cand_set;    // node enters the current component
  logic                 cand_q;      // pending minimum update
  logic [NB-1:0]        cand_n_q;
  logic [COST_BITS-1:0] cand_cost_q;
  logic                 cand_v_q;

  assign jn = j_q[NB-1:0];
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_LOAD);

  if (COST_BITS > InCost) begin : g_cw
    assign cost_in = {{(COST_BITS-InCost){1'b0}}, node_cost_i};
  end else begin : g_cn
    assign cost_in = node_cost_i[COST_BITS-1:0];
  end

  // Node count from a closing index, saturating at the depth.
  always_comb begin
    if ({1'b0, node_index_i} >= 7'(MAX_NODES)) n_new = CB'(MAX_NODES);
    else n_new = CB'(node_index_i) + CB'(1);
  end

  // Forward edge top->j in pass one, reversed edge j->top (row of j) in two.
  always_comb begin
    edge_hit = 1'b0;
    if (j_q < (NB+1)'(n_q)) begin
      if (state_q == S_P1_SCAN) edge_hit = row_q[jn] && !vis_q[jn];
      else edge_hit = row_q[top_q] && !vis_q[jn];
    end
  end

  // Root or pushed node of pass two; result moves to the output register.
  assign cand_set = (state_q == S_P2_START && !vis_q[top_q]) ||
                    (state_q == S_P2_SCAN && !scan_wait_q && edge_hit &&
                     sp_q < CB'(MAX_NODES));
  assign out_done = (state_q == S_P2_ROOT) && (k_q == '0) &&
                    (!out_v_q || !out_stall_i);

  // Graph memories: written on load.
  always_ff @(posedge clk_i) begin
    if (in_acc && ({1'b0, node_index_i} < 7'(MAX_NODES))) begin
      cst_mem[node_index_i[NB-1:0]] <= cost_in;
      adj_mem[node_index_i[NB-1:0]] <= adjacency_row_i;
    end
  end

  // Row read port: pass one reads top's row, pass two reads j's.
  always_ff @(posedge clk_i) begin
    if (state_q == S_P2_SCAN || state_q == S_P2_START) begin
      row_q <= adj_mem[jn];
    end else begin
      row_q <= adj_mem[top_q];
    end
  end

  // Accumulator control.
  always_comb begin
    ctl = '0;
    if (state_q == S_P2_INIT) begin
      ctl.init = 1'b1;
    end else if (state_q == S_P2_START) begin
      ctl.clr = 1'b1;
    end else if (state_q == S_P2_CLOSE) begin
      ctl.close = 1'b1;
    end else if (cand_v_q) begin
      ctl.cand = 1'b1;
    end
  end

  scc_acc #(.COST_BITS(COST_BITS)) u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .cost_i (cand_cost_q),
    .total_o(total)
  );

  // Sequencer: stack and scan memories hold push/pop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      vis_q <= '0;
      n_q <= '0; sp_q <= '0; fc_q <= '0; k_q <= '0;
      i_q <= '0; top_q <= '0; j_q <= '0;
      out_v_q <= 1'b0;
      out_q <= '0;
      scan_wait_q <= 1'b0;
    end else begin
      if (out_done) begin
        out_v_q <= 1'b1;
        out_q <= total;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc && last_node_i) begin
            n_q <= n_new; vis_q <= '0; fc_q <= '0; i_q <= '0;
            state_q <= S_P1_ROOT;
          end
        end
        S_P1_ROOT: begin
          if (i_q >= (NB+1)'(n_q)) begin
            state_q <= S_P2_INIT;
          end else if (vis_q[i_q[NB-1:0]]) begin
            i_q <= i_q + 1'b1;
          end else begin
            vis_q[i_q[NB-1:0]] <= 1'b1;
            stk_mem[0] <= i_q[NB-1:0];
            top_q <= i_q[NB-1:0]; j_q <= '0; sp_q <= CB'(1);
            scan_wait_q <= 1'b1;
            state_q <= S_P1_SCAN;
          end
        end
        S_P1_SCAN: begin
          if (scan_wait_q) begin
            scan_wait_q <= 1'b0;
          end else if (j_q >= (NB+1)'(n_q)) begin
            state_q <= S_P1_POP;
          end else if (edge_hit && sp_q < CB'(MAX_NODES)) begin
            scn_mem[sp_q[NB-1:0] - 1'b1] <= j_q + 1'b1;
            vis_q[jn] <= 1'b1;
            stk_mem[sp_q[NB-1:0]] <= jn;
            top_q <= jn; j_q <= '0; sp_q <= sp_q + 1'b1;
            scan_wait_q <= 1'b1;
          end else if (edge_hit) begin
            state_q <= S_P1_POP;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_P1_POP: begin
          if (fc_q < CB'(MAX_NODES)) begin
            fin_mem[fc_q[NB-1:0]] <= top_q;
            fc_q <= fc_q + 1'b1;
          end
          sp_q <= sp_q - 1'b1;
          if (sp_q == CB'(1)) begin
            i_q <= i_q + 1'b1;
            state_q <= S_P1_ROOT;
          end else begin
            top_q <= stk_mem[sp_q[NB-1:0] - 2'd2];
            j_q <= scn_mem[sp_q[NB-1:0] - 2'd2];
            scan_wait_q <= 1'b1;
            state_q <= S_P1_SCAN;
          end
        end
        S_P2_INIT: begin
          vis_q <= '0; k_q <= fc_q;
          state_q <= S_P2_ROOT;
        end
        S_P2_ROOT: begin
          if (k_q == '0) begin
            // wait here while the previous result word is still held
            if (out_done) state_q <= S_LOAD;
          end else begin
            k_q <= k_q - 1'b1;
            top_q <= fin_mem[k_q[NB-1:0] - 1'b1];
            state_q <= S_P2_START;
          end
        end
        S_P2_START: begin
          if (vis_q[top_q]) begin
            state_q <= S_P2_ROOT;
          end else begin
            vis_q[top_q] <= 1'b1;
            stk_mem[0] <= top_q; sp_q <= CB'(1); j_q <= '0;
            scan_wait_q <= 1'b1;
            state_q <= S_P2_SCAN;
          end
        end
        S_P2_SCAN: begin
          // row_q holds the registered row of j
          if (scan_wait_q) begin
            scan_wait_q <= 1'b0;
          end else if (j_q >= (NB+1)'(n_q)) begin
            sp_q <= sp_q - 1'b1;
            if (sp_q == CB'(1)) begin
              state_q <= S_P2_CLOSE;
            end else begin
              top_q <= stk_mem[sp_q[NB-1:0] - 2'd2];
              j_q <= scn_mem[sp_q[NB-1:0] - 2'd2];
              scan_wait_q <= 1'b1;
            end
          end else if (edge_hit && sp_q < CB'(MAX_NODES)) begin
            scn_mem[sp_q[NB-1:0] - 1'b1] <= j_q + 1'b1;
            vis_q[jn] <= 1'b1;
            stk_mem[sp_q[NB-1:0]] <= jn;
            top_q <= jn; j_q <= '0; sp_q <= sp_q + 1'b1;
            scan_wait_q <= 1'b1;
          end else if (edge_hit) begin
            sp_q <= sp_q - 1'b1;
            if (sp_q == CB'(1)) begin
              state_q <= S_P2_CLOSE;
            end else begin
              top_q <= stk_mem[sp_q[NB-1:0] - 2'd2];
              j_q <= scn_mem[sp_q[NB-1:0] - 2'd2];
              scan_wait_q <= 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
            scan_wait_q <= 1'b1;
          end
        end
        S_P2_CLOSE: begin
          state_q <= S_P2_ROOT;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // Component node's index is registered, then its cost is read and offered to the minimum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= 1'b0;
      cand_n_q <= '0;
      cand_v_q <= 1'b0;
    end else begin
      cand_q <= cand_set;
      if (cand_set) cand_n_q <= (state_q == S_P2_START) ? top_q : jn;
      cand_v_q <= cand_q;
    end
  end
  always_ff @(posedge clk_i) begin
    cand_cost_q <= cst_mem[cand_n_q];
  end

  assign out_valid_o = out_v_q;
  assign total_min_cost_o = out_q;

  // Checks on sequencer bookkeeping.
  `SCC_ASSERT_IMP(a_p2_sp_bound, clk_i, rst_ni,
    state_q == S_P2_SCAN, sp_q <= CB'(MAX_NODES) && sp_q != '0)
  `SCC_ASSERT_IMP(a_sp_bound, clk_i, rst_ni,
    state_q == S_P1_SCAN, sp_q <= CB'(MAX_NODES) && sp_q != '0)
  `SCC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_v_q && out_stall_i,
    out_v_q && $stable(total_min_cost_o))
endmodule
